>>> design/uto_pkg.sv
`timescale 1ns / 1ps
// Package for the two-sensor obstacle locator: transaction structs, class codes
// and datapath widths. It has no dependencies of its own.
package uto_pkg;

    // Number of root bits: the root of the radicand stays below 2^30.
    localparam int ROOT_W = 30;
    // Radicand width, two bits per root bit.
    localparam int RAD_W  = 2 * ROOT_W;
    // Quotient bits of the final rounding divide.
    localparam int QUO_W  = 16;
    // Dividend width of the final rounding divide.
    localparam int NUM_W  = 48;

    typedef enum logic [2:0] {
        CLS_NORMAL  = 3'd0,
        CLS_OVER    = 3'd1,
        CLS_BLIND   = 3'd2,
        CLS_NOISE   = 3'd3,
        CLS_INVALID = 3'd4
    } t_cls;

    localparam logic [7:0] STAT_OK    = 8'd0;
    localparam logic [7:0] STAT_NOISE = 8'd2;
    localparam logic [7:0] STAT_BLIND = 8'd16;

    typedef struct packed {
        logic               apex_down;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic [13:0]        dist_left;
        logic [13:0]        dist_right;
        logic [7:0]         stat_left;
        logic [7:0]         stat_right;
    } t_in;

    typedef struct packed {
        logic signed [15:0] obs_x;
        logic signed [15:0] obs_y;
        logic [2:0]         obs_class;
    } t_out;

    // Classified transaction handed from the front end to the back end.
    typedef struct packed {
        t_in  item;
        logic calc;
        t_cls cls;
    } t_job;

    // Queue status seen by the top level.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Fields that ride along the arithmetic pipeline; stage 2 may clear calc and set the class to invalid.
    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic               down;
        logic               calc;
        t_cls               cls;
    } t_side;

    typedef struct packed {
        logic signed [31:0] n;
        logic [29:0]        d;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        t_side              side;
    } t_mid;

endpackage

>>> design/uto_front.sv
`timescale 1ns / 1ps
// Front end: registers each accepted transaction and classifies it by status
// and distance. Depends on uto_pkg.
module uto_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  uto_pkg::t_in  i_item,
    output logic          o_valid,
    output uto_pkg::t_job o_job
);

    logic          r_valid;
    uto_pkg::t_job r_job;
    uto_pkg::t_job n_job;

    // Status decode: good statuses go to the arithmetic unless a distance is zero.
    always_comb begin
        n_job.item = i_item;
        n_job.calc = 1'b0;
        priority if (i_item.stat_left == uto_pkg::STAT_OK &&
                     i_item.stat_right == uto_pkg::STAT_OK) begin
            if (i_item.dist_left == 14'd0 || i_item.dist_right == 14'd0) begin
                n_job.cls = uto_pkg::CLS_OVER;
            end else begin
                n_job.cls  = uto_pkg::CLS_NORMAL;
                n_job.calc = 1'b1;
            end
        end else if (i_item.stat_left == uto_pkg::STAT_BLIND ||
                     i_item.stat_right == uto_pkg::STAT_BLIND) begin
            n_job.cls = uto_pkg::CLS_BLIND;
        end else if (i_item.stat_left == uto_pkg::STAT_NOISE ||
                     i_item.stat_right == uto_pkg::STAT_NOISE) begin
            n_job.cls = uto_pkg::CLS_NOISE;
        end else begin
            n_job.cls = uto_pkg::CLS_INVALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_take;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;

endmodule

>>> design/uto_queue.sv
`timescale 1ns / 1ps
// Two-entry queue between front end and back end; the back end drains one
// transaction per cycle. Depends on uto_pkg.
module uto_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  uto_pkg::t_job   i_job,
    output logic            o_pop,
    output uto_pkg::t_job   o_job,
    output uto_pkg::t_qstat o_stat
);

    uto_pkg::t_job r_mem [0:1];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          w_pop;

    assign w_pop = (r_cnt != 2'd0);

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_pop        = w_pop;
    assign o_job        = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

endmodule

>>> design/uto_back.sv
`timescale 1ns / 1ps
// Back end: pipelined exact trilateration (squares, validity test, digit-serial
// square root, products and a restoring rounding divide). Depends on uto_pkg.
module uto_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  uto_pkg::t_job i_job,
    output logic          o_valid,
    output uto_pkg::t_out o_result
);

    // ---------------- Stage 1: differences and squares ----------------
    logic signed [16:0] w_dx, w_dy;
    logic signed [33:0] w_dx2, w_dy2;
    logic [14:0]        w_sum;
    logic [13:0]        w_dif;
    uto_pkg::t_side     w_side1;

    logic               r1_v;
    logic signed [16:0] r1_dx, r1_dy;
    logic [31:0]        r1_dx2, r1_dy2;
    logic [27:0]        r1_dl2, r1_dr2, r1_dif2;
    logic [29:0]        r1_sum2;
    uto_pkg::t_side     r1_side;

    assign w_dx  = $signed({i_job.item.bx[15], i_job.item.bx})
                 - $signed({i_job.item.ax[15], i_job.item.ax});
    assign w_dy  = $signed({i_job.item.by[15], i_job.item.by})
                 - $signed({i_job.item.ay[15], i_job.item.ay});
    assign w_dx2 = w_dx * w_dx;
    assign w_dy2 = w_dy * w_dy;
    assign w_sum = {1'b0, i_job.item.dist_left} + {1'b0, i_job.item.dist_right};
    assign w_dif = (i_job.item.dist_left > i_job.item.dist_right)
                 ? i_job.item.dist_left - i_job.item.dist_right
                 : i_job.item.dist_right - i_job.item.dist_left;

    always_comb begin
        w_side1.ax   = i_job.item.ax;
        w_side1.ay   = i_job.item.ay;
        w_side1.down = i_job.item.apex_down;
        w_side1.calc = i_job.calc;
        w_side1.cls  = i_job.cls;
    end

    always_ff @(posedge i_clk) begin
        r1_dx   <= w_dx;
        r1_dy   <= w_dy;
        r1_dx2  <= w_dx2[31:0];
        r1_dy2  <= w_dy2[31:0];
        r1_dl2  <= i_job.item.dist_left * i_job.item.dist_left;
        r1_dr2  <= i_job.item.dist_right * i_job.item.dist_right;
        r1_sum2 <= w_sum * w_sum;
        r1_dif2 <= w_dif * w_dif;
        r1_side <= w_side1;
    end

    // ---------------- Stage 2: base squared and triangle test ----------------
    logic [32:0]        w_d;
    logic [32:0]        w_dif25;
    logic               w_ok;
    logic signed [34:0] w_n;
    uto_pkg::t_mid      w_mid2;

    logic               r2_v;
    logic [27:0]        r2_dl2;
    uto_pkg::t_mid      r2_mid;

    assign w_d     = {1'b0, r1_dx2} + {1'b0, r1_dy2};
    assign w_dif25 = {1'b0, r1_dif2, 4'b0} + {2'b0, r1_dif2, 3'b0} + {5'b0, r1_dif2};
    assign w_ok    = ({3'b0, r1_sum2} > w_d) && ({4'b0, w_dif25} < {w_d, 4'b0});
    assign w_n     = $signed({2'b0, w_d}) + $signed({7'b0, r1_dl2})
                   - $signed({7'b0, r1_dr2});

    always_comb begin
        w_mid2.n    = w_n[31:0];
        w_mid2.d    = w_d[29:0];
        w_mid2.dx   = r1_dx;
        w_mid2.dy   = r1_dy;
        w_mid2.side = r1_side;
        if (r1_side.calc && !w_ok) begin
            w_mid2.side.calc = 1'b0;
            w_mid2.side.cls  = uto_pkg::CLS_INVALID;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_dl2 <= r1_dl2;
        r2_mid <= w_mid2;
    end

    // ---------------- Stage 3: 4*D*dl^2 and N^2 ----------------
    logic signed [31:0] w_nabs;
    logic [57:0]        w_ddl;

    logic               r3_v;
    logic [59:0]        r3_a4;
    logic [61:0]        r3_n2;
    uto_pkg::t_mid      r3_mid;

    assign w_nabs = r2_mid.n[31] ? -r2_mid.n : r2_mid.n;
    assign w_ddl  = r2_mid.d * r2_dl2;

    always_ff @(posedge i_clk) begin
        r3_a4  <= {w_ddl, 2'b0};
        r3_n2  <= w_nabs[30:0] * w_nabs[30:0];
        r3_mid <= r2_mid;
    end

    // ---------------- Stage 4: radicand, clamped at zero ----------------
    logic [61:0] w_diff4;

    logic [uto_pkg::RAD_W-1:0]  r_sq_rad [0:uto_pkg::ROOT_W];
    logic [uto_pkg::ROOT_W+2:0] r_sq_rem [0:uto_pkg::ROOT_W];
    logic [uto_pkg::ROOT_W-1:0] r_sq_q   [0:uto_pkg::ROOT_W];
    uto_pkg::t_mid              r_sq_mid [0:uto_pkg::ROOT_W];
    logic                       r_sq_v   [0:uto_pkg::ROOT_W];

    assign w_diff4 = {2'b0, r3_a4} - r3_n2;

    always_ff @(posedge i_clk) begin
        r_sq_rad[0] <= ({2'b0, r3_a4} > r3_n2) ? w_diff4[uto_pkg::RAD_W-1:0] : '0;
        r_sq_rem[0] <= '0;
        r_sq_q[0]   <= '0;
        r_sq_mid[0] <= r3_mid;
    end

    // ---------------- Square root: one root bit per stage ----------------
    for (genvar k = 1; k <= uto_pkg::ROOT_W; k++) begin : g_sq
        logic [uto_pkg::ROOT_W+2:0] w_rem_sh;
        logic [uto_pkg::ROOT_W+2:0] w_trial;
        logic                       w_ge;

        assign w_rem_sh = {r_sq_rem[k-1][uto_pkg::ROOT_W:0],
                           r_sq_rad[k-1][uto_pkg::RAD_W-1 -: 2]};
        assign w_trial  = {1'b0, r_sq_q[k-1], 2'b01};
        assign w_ge     = (w_rem_sh >= w_trial);

        always_ff @(posedge i_clk) begin
            r_sq_rad[k] <= {r_sq_rad[k-1][uto_pkg::RAD_W-3:0], 2'b00};
            r_sq_rem[k] <= w_ge ? w_rem_sh - w_trial : w_rem_sh;
            r_sq_q[k]   <= {r_sq_q[k-1][uto_pkg::ROOT_W-2:0], w_ge};
            r_sq_mid[k] <= r_sq_mid[k-1];
        end
    end

    // ---------------- Stage 5: round the root and apply the apex side ----------------
    logic [30:0]        w_root;
    logic signed [31:0] w_s;

    logic               r5_v;
    logic signed [31:0] r5_s;
    uto_pkg::t_mid      r5_mid;

    assign w_root = {1'b0, r_sq_q[uto_pkg::ROOT_W]}
                  + {30'b0, (r_sq_rem[uto_pkg::ROOT_W] >
                             {3'b0, r_sq_q[uto_pkg::ROOT_W]})};
    assign w_s    = r_sq_mid[uto_pkg::ROOT_W].side.down
                  ? -$signed({1'b0, w_root}) : $signed({1'b0, w_root});

    always_ff @(posedge i_clk) begin
        r5_s   <= w_s;
        r5_mid <= r_sq_mid[uto_pkg::ROOT_W];
    end

    // ---------------- Stage 6: the four products ----------------
    logic               r6_v;
    logic signed [48:0] r6_p1, r6_p2, r6_p3, r6_p4;
    logic [29:0]        r6_d;
    uto_pkg::t_side     r6_side;

    always_ff @(posedge i_clk) begin
        r6_p1   <= r5_mid.n * r5_mid.dx;
        r6_p2   <= r5_s * r5_mid.dy;
        r6_p3   <= r5_mid.n * r5_mid.dy;
        r6_p4   <= r5_s * r5_mid.dx;
        r6_d    <= r5_mid.d;
        r6_side <= r5_mid.side;
    end

    // ---------------- Stage 7: numerators ----------------
    logic               r7_v;
    logic signed [49:0] r7_xn, r7_yn;
    logic [29:0]        r7_d;
    uto_pkg::t_side     r7_side;

    always_ff @(posedge i_clk) begin
        r7_xn   <= 50'(r6_p1) - 50'(r6_p2);
        r7_yn   <= 50'(r6_p3) + 50'(r6_p4);
        r7_d    <= r6_d;
        r7_side <= r6_side;
    end

    // ---------------- Stage 8: magnitudes plus half the divisor ----------------
    logic signed [49:0] w_xm, w_ym;

    logic [uto_pkg::NUM_W-1:0] r_dv_ux  [0:uto_pkg::QUO_W];
    logic [uto_pkg::NUM_W-1:0] r_dv_uy  [0:uto_pkg::QUO_W];
    logic [uto_pkg::QUO_W-1:0] r_dv_qx  [0:uto_pkg::QUO_W];
    logic [uto_pkg::QUO_W-1:0] r_dv_qy  [0:uto_pkg::QUO_W];
    logic [30:0]               r_dv_den [0:uto_pkg::QUO_W];
    logic                      r_dv_sx  [0:uto_pkg::QUO_W];
    logic                      r_dv_sy  [0:uto_pkg::QUO_W];
    uto_pkg::t_side            r_dv_sd  [0:uto_pkg::QUO_W];
    logic                      r_dv_v   [0:uto_pkg::QUO_W];

    assign w_xm = r7_xn[49] ? -r7_xn : r7_xn;
    assign w_ym = r7_yn[49] ? -r7_yn : r7_yn;

    always_ff @(posedge i_clk) begin
        r_dv_ux[0]  <= w_xm[uto_pkg::NUM_W-1:0] + {18'b0, r7_d};
        r_dv_uy[0]  <= w_ym[uto_pkg::NUM_W-1:0] + {18'b0, r7_d};
        r_dv_qx[0]  <= '0;
        r_dv_qy[0]  <= '0;
        r_dv_den[0] <= {r7_d, 1'b0};
        r_dv_sx[0]  <= r7_xn[49];
        r_dv_sy[0]  <= r7_yn[49];
        r_dv_sd[0]  <= r7_side;
    end

    // ---------------- Restoring divide: one quotient bit per stage ----------------
    for (genvar k = 1; k <= uto_pkg::QUO_W; k++) begin : g_dv
        logic [uto_pkg::NUM_W-1:0] w_sh;
        logic                      w_gx, w_gy;

        assign w_sh = {17'b0, r_dv_den[k-1]} << (uto_pkg::QUO_W - k);
        assign w_gx = (r_dv_ux[k-1] >= w_sh);
        assign w_gy = (r_dv_uy[k-1] >= w_sh);

        always_ff @(posedge i_clk) begin
            r_dv_ux[k]  <= w_gx ? r_dv_ux[k-1] - w_sh : r_dv_ux[k-1];
            r_dv_uy[k]  <= w_gy ? r_dv_uy[k-1] - w_sh : r_dv_uy[k-1];
            r_dv_qx[k]  <= {r_dv_qx[k-1][uto_pkg::QUO_W-2:0], w_gx};
            r_dv_qy[k]  <= {r_dv_qy[k-1][uto_pkg::QUO_W-2:0], w_gy};
            r_dv_den[k] <= r_dv_den[k-1];
            r_dv_sx[k]  <= r_dv_sx[k-1];
            r_dv_sy[k]  <= r_dv_sy[k-1];
            r_dv_sd[k]  <= r_dv_sd[k-1];
        end
    end

    // ---------------- Output: sign, offset from point a, saturation ----------------
    uto_pkg::t_side     w_fs;
    logic signed [16:0] w_qx, w_qy;
    logic signed [17:0] w_px, w_py;
    uto_pkg::t_out      n_out;

    logic               r_out_v;
    uto_pkg::t_out      r_out;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] res;
        if (v[17:15] == 3'b000 || v[17:15] == 3'b111) begin
            res = v[15:0];
        end else if (v[17]) begin
            res = 16'sh8000;
        end else begin
            res = 16'sh7FFF;
        end
        return res;
    endfunction

    assign w_fs = r_dv_sd[uto_pkg::QUO_W];
    assign w_qx = r_dv_sx[uto_pkg::QUO_W] ? -$signed({1'b0, r_dv_qx[uto_pkg::QUO_W]})
                                          : $signed({1'b0, r_dv_qx[uto_pkg::QUO_W]});
    assign w_qy = r_dv_sy[uto_pkg::QUO_W] ? -$signed({1'b0, r_dv_qy[uto_pkg::QUO_W]})
                                          : $signed({1'b0, r_dv_qy[uto_pkg::QUO_W]});
    assign w_px = $signed({{2{w_fs.ax[15]}}, w_fs.ax}) + $signed({w_qx[16], w_qx});
    assign w_py = $signed({{2{w_fs.ay[15]}}, w_fs.ay}) + $signed({w_qy[16], w_qy});

    always_comb begin
        n_out.obs_class = w_fs.cls;
        if (w_fs.calc) begin
            n_out.obs_x = sat16(w_px);
            n_out.obs_y = sat16(w_py);
        end else begin
            n_out.obs_x = w_fs.ax;
            n_out.obs_y = w_fs.ay;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // Valid flags through every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r5_v    <= 1'b0;
            r6_v    <= 1'b0;
            r7_v    <= 1'b0;
            r_out_v <= 1'b0;
            for (int i = 0; i <= uto_pkg::ROOT_W; i++) begin
                r_sq_v[i] <= 1'b0;
            end
            for (int i = 0; i <= uto_pkg::QUO_W; i++) begin
                r_dv_v[i] <= 1'b0;
            end
        end else begin
            r1_v      <= i_valid;
            r2_v      <= r1_v;
            r3_v      <= r2_v;
            r_sq_v[0] <= r3_v;
            for (int i = 1; i <= uto_pkg::ROOT_W; i++) begin
                r_sq_v[i] <= r_sq_v[i-1];
            end
            r5_v      <= r_sq_v[uto_pkg::ROOT_W];
            r6_v      <= r5_v;
            r7_v      <= r6_v;
            r_dv_v[0] <= r7_v;
            for (int i = 1; i <= uto_pkg::QUO_W; i++) begin
                r_dv_v[i] <= r_dv_v[i-1];
            end
            r_out_v   <= r_dv_v[uto_pkg::QUO_W];
        end
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out;

endmodule

>>> design/ultrasonic_triangle_obstacle_locate_top.sv
`timescale 1ns / 1ps
// Two-sensor ultrasonic obstacle locator. Results of every class pass through
// the same stages. Throughput: one transaction per cycle while busy is low;
// the square root (one bit per stage) and the rounding divide (one quotient
// bit per stage) are fully pipelined.
// Reset is synchronous, active low, clears all valid flags; busy is high in reset.
// Results cannot be stalled by the receiver.
module ultrasonic_triangle_obstacle_locate_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  uto_pkg::t_in  i_item,
    output logic          o_done,
    output uto_pkg::t_out o_result
);

    logic            w_take;
    logic            w_push;
    logic            w_pop;
    uto_pkg::t_job   w_fjob;
    uto_pkg::t_job   w_qjob;
    uto_pkg::t_qstat w_qstat;

    // A transaction is taken when start meets a free queue outside reset.
    assign busy   = w_qstat.full | ~i_rst_n;
    assign w_take = start & ~busy;

    uto_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_item  (i_item),
        .o_valid (w_push),
        .o_job   (w_fjob)
    );

    uto_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .o_pop   (w_pop),
        .o_job   (w_qjob),
        .o_stat  (w_qstat)
    );

    uto_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_pop),
        .i_job    (w_qjob),
        .o_valid  (o_done),
        .o_result (o_result)
    );

    // An accepted transaction is registered in the front end, pushed into the queue and then popped to the back end.
    a_take_to_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> ##2 w_pop)
        else $error("accepted transaction did not reach the back end");

    // The queue never gets a push while it is full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.full |-> !w_push)
        else $error("queue overflow");

    // Every result comes out with a defined class code.
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.obs_class <= 3'd4))
        else $error("undefined result class");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the two-sensor ultrasonic obstacle locator.
// Depends on uto_pkg and ultrasonic_triangle_obstacle_locate_top only.
module tb;
    import uto_pkg::*;

    localparam int LATENCY = 57;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_in   i_item;
    logic  o_done;
    t_out  o_result;

    t_out  expected_points[$];
    int    mismatches;
    int    accepted;
    int    results_seen;
    int    class_count[5];

    ultrasonic_triangle_obstacle_locate_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_result(o_result)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Root of a 64-bit value, rounded to nearest.
    function automatic longint unsigned root_nearest(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (v > r) r = r + 1;
        return r;
    endfunction

    // Quotient rounded to nearest, halves away from zero.
    function automatic longint quot_nearest(input longint num, input longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // Computes the obstacle point and class for one measurement pair.
    function automatic t_out locate_obstacle(input t_in it);
        t_out   r;
        longint ax, ay, dx, dy, dl, dr, d2, sum, dif, n, s, a4, n2;
        ax = it.ax;
        ay = it.ay;
        dx = longint'(it.bx) - ax;
        dy = longint'(it.by) - ay;
        dl = it.dist_left;
        dr = it.dist_right;
        r.obs_x = it.ax;
        r.obs_y = it.ay;
        if (it.stat_left == STAT_OK && it.stat_right == STAT_OK) begin
            if (dl == 0 || dr == 0) begin
                r.obs_class = CLS_OVER;
            end else begin
                d2 = dx * dx + dy * dy;
                sum = dl + dr;
                dif = (dl > dr) ? dl - dr : dr - dl;
                if (sum * sum > d2 && 25 * dif * dif < 16 * d2) begin
                    n = d2 + dl * dl - dr * dr;
                    a4 = 4 * d2 * dl * dl;
                    n2 = n * n;
                    s = root_nearest((a4 > n2) ? a4 - n2 : 0);
                    if (it.apex_down) s = -s;
                    r.obs_x = clamp16(ax + quot_nearest(n * dx - s * dy, 2 * d2));
                    r.obs_y = clamp16(ay + quot_nearest(n * dy + s * dx, 2 * d2));
                    r.obs_class = CLS_NORMAL;
                end else begin
                    r.obs_class = CLS_INVALID;
                end
            end
        end else if (it.stat_left == STAT_BLIND || it.stat_right == STAT_BLIND) begin
            r.obs_class = CLS_BLIND;
        end else if (it.stat_left == STAT_NOISE || it.stat_right == STAT_NOISE) begin
            r.obs_class = CLS_NOISE;
        end else begin
            r.obs_class = CLS_INVALID;
        end
        return r;
    endfunction

    // Result checker: every strobed result against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            results_seen <= results_seen + 1;
            if (expected_points.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("Unexpected result x=%0d y=%0d class=%0d",
                             o_result.obs_x, o_result.obs_y, o_result.obs_class);
            end else begin
                t_out e;
                e = expected_points.pop_front();
                if (e.obs_class <= 4) class_count[e.obs_class]++;
                if (o_result !== e) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("Mismatch: expected x=%0d y=%0d class=%0d, got x=%0d y=%0d class=%0d",
                                 e.obs_x, e.obs_y, e.obs_class,
                                 o_result.obs_x, o_result.obs_y, o_result.obs_class);
                end
            end
        end
    end

    // Drives one transaction with an idle gap of the given odds beforehand.
    task automatic send_item(input t_in it, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_points.push_back(locate_obstacle(it));
        accepted++;
    endtask

    // Random measurement pair; mostly valid triangles near a short baseline.
    function automatic t_in random_item();
        t_in it;
        int  pick;
        int  base;
        it = t_in'(($bits(t_in))'({$urandom, $urandom, $urandom, $urandom}));
        pick = $urandom_range(99);
        if (pick < 65) begin
            it.ax = 16'($urandom_range(4000) - 2000);
            it.ay = 16'($urandom_range(4000) - 2000);
            it.bx = 16'(it.ax + $urandom_range(1200) - 600);
            it.by = 16'(it.ay + $urandom_range(1200) - 600);
            base = $urandom_range(600) + 1;
            it.dist_left  = 14'($urandom_range(3000) + base / 2);
            it.dist_right = 14'(it.dist_left + $urandom_range(base) - base / 2);
            it.stat_left  = STAT_OK;
            it.stat_right = STAT_OK;
        end else if (pick < 80) begin
            it.stat_left  = STAT_OK;
            it.stat_right = STAT_OK;
        end else if (pick < 90) begin
            it.stat_left  = ($urandom_range(1)) ? STAT_BLIND : STAT_NOISE;
            it.stat_right = ($urandom_range(1)) ? STAT_OK : STAT_NOISE;
        end
        return it;
    endfunction

    // Directed rows: fields plus an optional typed-in expectation.
    typedef struct {
        t_in  item;
        logic known;
        t_out want;
    } t_row;

    t_row rows[$];

    function automatic t_in mk(input logic dn, input int ax, input int ay,
                               input int bx, input int by, input int dl,
                               input int dr, input int sl, input int sr);
        t_in it;
        it.apex_down  = dn;
        it.ax = 16'(ax);
        it.ay = 16'(ay);
        it.bx = 16'(bx);
        it.by = 16'(by);
        it.dist_left  = 14'(dl);
        it.dist_right = 14'(dr);
        it.stat_left  = 8'(sl);
        it.stat_right = 8'(sr);
        return it;
    endfunction

    function automatic t_row fixed(input t_in it, input int x, input int y,
                                   input t_cls c);
        t_row r;
        r.item = it;
        r.known = 1'b1;
        r.want.obs_x = 16'(x);
        r.want.obs_y = 16'(y);
        r.want.obs_class = c;
        return r;
    endfunction

    function automatic t_row calc(input t_in it);
        t_row r;
        r.item = it;
        r.known = 1'b0;
        r.want = '0;
        return r;
    endfunction

    // Stimulus sequence.
    initial begin
        int phase_idle[4];
        int n_phase;
        mismatches = 0;
        accepted = 0;
        results_seen = 0;
        foreach (class_count[k]) class_count[k] = 0;
        start   = 1'b0;
        i_item  = '0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows.push_back(fixed(mk(0, 0, 0, 100, 0, 0, 50, 0, 0), 0, 0, CLS_OVER));
        rows.push_back(fixed(mk(0, -32768, 32767, 0, 0, 100, 0, 0, 0),
                             -32768, 32767, CLS_OVER));
        rows.push_back(fixed(mk(0, 5, 6, 5, 6, 100, 100, 0, 0), 5, 6, CLS_INVALID));
        rows.push_back(fixed(mk(0, 0, 0, 100, 0, 10, 10, 0, 0), 0, 0, CLS_INVALID));
        rows.push_back(fixed(mk(1, 0, 0, 100, 0, 500, 10, 0, 0), 0, 0, CLS_INVALID));
        rows.push_back(fixed(mk(0, 7, -7, 0, 0, 1, 1, 16, 2), 7, -7, CLS_BLIND));
        rows.push_back(fixed(mk(0, 7, -7, 0, 0, 1, 1, 2, 0), 7, -7, CLS_NOISE));
        rows.push_back(fixed(mk(0, 7, -7, 0, 0, 1, 1, 0, 255), 7, -7, CLS_INVALID));
        rows.push_back(fixed(mk(0, 7, -7, 0, 0, 1, 1, 255, 16), 7, -7, CLS_BLIND));
        rows.push_back(fixed(mk(1, 0, 0, 0, 0, 16383, 16383, 128, 1), 0, 0, CLS_INVALID));
        rows.push_back(calc(mk(0, 0, 0, 100, 0, 100, 100, 0, 0)));
        rows.push_back(calc(mk(1, 0, 0, 100, 0, 100, 100, 0, 0)));
        rows.push_back(calc(mk(0, 32000, 32000, 32767, 32767, 16383, 16000, 0, 0)));
        rows.push_back(calc(mk(1, -32768, -32768, -20000, -32768, 16383, 16383, 0, 0)));
        rows.push_back(calc(mk(0, -32768, 32767, 32767, -32768, 16383, 16383, 0, 0)));
        rows.push_back(calc(mk(0, 0, 0, 0, 1, 1, 1, 0, 0)));
        rows.push_back(calc(mk(1, 100, -200, -300, 400, 700, 600, 0, 0)));
        rows.push_back(calc(mk(0, 32767, 0, 32767, 20000, 16383, 16383, 0, 0)));

        foreach (rows[i]) begin
            send_item(rows[i].item, 0);
            if (rows[i].known) begin
                void'(expected_points.pop_back());
                expected_points.push_back(rows[i].want);
            end
        end

        // Hold off until the pipeline drains.
        start <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);

        phase_idle[0] = 0;
        phase_idle[1] = 74;
        phase_idle[2] = 0;
        phase_idle[3] = 35;
        n_phase = 1350 / 4;
        for (int p = 0; p < 4; p++) begin
            for (int i = 0; i < n_phase; i++) begin
                if (phase_idle[p] != 0 && ($urandom_range(99) < 10))
                    send_item(random_item(), 0);
                else
                    send_item(random_item(), phase_idle[p]);
            end
        end
        start <= 1'b0;

        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("Sent %0d transactions under four idle phases; %0d results checked.",
                 accepted, results_seen);
        $display("Classes normal/over/blind/noise/invalid: %0d/%0d/%0d/%0d/%0d",
                 class_count[0], class_count[1], class_count[2], class_count[3],
                 class_count[4]);
        if (mismatches == 0 && expected_points.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #200000;
        $display("Timeout");
        $display("DONE: errors detected");
        $finish;
    end

endmodule
